[rtl/core/hdr_tone_map_srgb_encode_top_defines.svh]
// Assertion helpers used by the core top module.
`ifndef HDR_TONE_MAP_SRGB_ENCODE_TOP_DEFINES_SVH
`define HDR_TONE_MAP_SRGB_ENCODE_TOP_DEFINES_SVH

// Clocked property, off while reset is asserted.
`define HTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold.
`define HTM_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[rtl/core/htm_srgb_pkg.sv]
package htm_srgb_pkg;

  localparam int FracBitsDef = 16;
  localparam int ChanW       = 24;
  localparam int CodeW       = 8;
  localparam int ThrW        = 25;
  localparam int Steps       = CodeW;
  localparam int TabN        = 1 << CodeW;

  typedef struct packed {
    logic signed [ChanW-1:0] red_linear;
    logic signed [ChanW-1:0] green_linear;
    logic signed [ChanW-1:0] blue_linear;
  } pix_t;

  typedef struct packed {
    logic [CodeW-1:0] red_code;
    logic [CodeW-1:0] green_code;
    logic [CodeW-1:0] blue_code;
  } code_t;

  typedef logic [TabN-1:0][ThrW-1:0] thr_tab_t;

  // Room for v^5 * 10761^12 and its right-hand counterpart (about 282 bits).
  typedef logic [319:0] wide_t;

  function automatic wide_t wpow_f(wide_t b, int n);
    wide_t r;
    r = wide_t'(1);
    for (int i = 0; i < n; i++) r = r * b;
    return r;
  endfunction

  // Smallest raw input reaching each code; code = largest c with v >= tab[c].
  // Elaboration-time only; every threshold but those of codes 0 and 255 is an exact integer search.
  function automatic thr_tab_t thr_tab_f(int fb);
    thr_tab_t t;
    longint   one_l;
    longint   top_l;
    longint   vb;
    longint   lo;
    longint   hi;
    longint   mid;
    longint   dn;
    wide_t    k_in;
    wide_t    k_c;
    one_l = longint'(1) << fb;
    top_l = longint'(1) << ChanW;
    t     = '0;
    // last raw value still on the linear toe
    lo = 0;
    hi = top_l;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (mid * longint'(10000000 - 31308) > longint'(31308) * one_l) hi = mid;
      else lo = mid + 1;
    end
    vb   = lo - 1;
    k_in = wpow_f(wide_t'(10761), 12);
    for (int c = 0; c < TabN; c++) begin
      if (c == 0) begin
        t[c] = '0;
      end else if (c == TabN - 1) begin
        t[c] = ThrW'(top_l);
      end else begin
        dn = longint'(32946 - 10 * c);
        lo = 0;
        hi = top_l;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (mid * dn >= longint'(10 * c) * one_l) hi = mid;
          else lo = mid + 1;
        end
        if (lo <= vb) begin
          t[c] = ThrW'(lo);
        end else begin
          k_c = wpow_f(wide_t'(40 * c + 561), 12);
          lo  = vb + 1;
          hi  = top_l;
          while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (wpow_f(wide_t'(mid), 5) * k_in >= k_c * wpow_f(wide_t'(one_l + mid), 5))
              hi = mid;
            else
              lo = mid + 1;
          end
          t[c] = ThrW'(lo);
        end
      end
    end
    return t;
  endfunction

endpackage

[rtl/core/hdr_tone_map_srgb_encode_top.sv]
// Channel   Direction  Handshake            Payload
// pixel     in         start_i / busy_o     pix_i  (three Q-format signed channels)
// code      out        done_o strobe        code_o (three 8-bit sRGB codes)
//
// One pixel per cycle; busy_o is tied low, the block never refuses a beat.
// Each channel lane holds one search stage per code bit.
// done_o pulses for a single cycle; the receiver cannot stall it.
// rst_ni clears only the valid pipeline; data stages carry no reset.
module hdr_tone_map_srgb_encode_top #(
  parameter int FracBits = htm_srgb_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  htm_srgb_pkg::pix_t  pix_i,
  output logic                busy_o,
  output logic                done_o,
  output htm_srgb_pkg::code_t code_o
);

  `include "hdr_tone_map_srgb_encode_top_defines.svh"

  localparam int Steps = htm_srgb_pkg::Steps;

  logic             accept;
  logic [Steps-1:0] vld_q;
  logic [Steps-1:0] vld_d;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // three identical lanes, one per color channel
  htm_srgb_lane #(.FracBits(FracBits)) u_lane_r (
    .clk_i(clk_i), .lin_i(pix_i.red_linear),   .code_o(code_o.red_code)
  );
  htm_srgb_lane #(.FracBits(FracBits)) u_lane_g (
    .clk_i(clk_i), .lin_i(pix_i.green_linear), .code_o(code_o.green_code)
  );
  htm_srgb_lane #(.FracBits(FracBits)) u_lane_b (
    .clk_i(clk_i), .lin_i(pix_i.blue_linear),  .code_o(code_o.blue_code)
  );

  // valid travels alongside the lane stages
  assign vld_d = {vld_q[Steps-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign done_o = vld_q[Steps-1];

  `HTM_ASSERT(a_latency, accept |-> ##8 done_o, "result beat missing after 8 cycles")
  `HTM_ASSERT_NEVER(a_busy, busy_o, "busy raised")
  `HTM_ASSERT_NEVER(a_code_max, done_o && (code_o.red_code == 8'hFF ||
    code_o.green_code == 8'hFF || code_o.blue_code == 8'hFF), "code 255 produced")

endmodule

[rtl/core/htm_srgb_lane.sv]
// One channel: 8-stage binary search over the code threshold table.
module htm_srgb_lane #(
  parameter int FracBits = htm_srgb_pkg::FracBitsDef
) (
  input  logic                                 clk_i,
  input  logic signed [htm_srgb_pkg::ChanW-1:0] lin_i,
  output logic        [htm_srgb_pkg::CodeW-1:0] code_o
);

  localparam int ThrW  = htm_srgb_pkg::ThrW;
  localparam int CodeW = htm_srgb_pkg::CodeW;
  localparam int Steps = htm_srgb_pkg::Steps;
  localparam htm_srgb_pkg::thr_tab_t Thr = htm_srgb_pkg::thr_tab_f(FracBits);

  logic [Steps-1:0][ThrW-1:0]  v_q;
  logic [Steps-1:0][CodeW-1:0] c_q;
  logic [Steps-1:0][ThrW-1:0]  v_d;
  logic [Steps-1:0][CodeW-1:0] c_d;

  always_comb begin
    for (int k = 0; k < Steps; k++) begin
      logic [ThrW-1:0]  v_in;
      logic [CodeW-1:0] c_in;
      logic [CodeW-1:0] cand;
      if (k == 0) begin
        // negative clamps to zero, which sits below every nonzero threshold
        v_in = lin_i[htm_srgb_pkg::ChanW-1] ? '0 : ThrW'(lin_i);
        c_in = '0;
      end else begin
        v_in = v_q[k-1];
        c_in = c_q[k-1];
      end
      cand   = c_in | (CodeW'(1) << (Steps - 1 - k));
      v_d[k] = v_in;
      c_d[k] = (v_in >= Thr[cand]) ? cand : c_in;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    c_q <= c_d;
  end

  assign code_o = c_q[Steps-1];

endmodule

[verif/hdr_tone_map_srgb_encode_top_test.sv]
module hdr_tone_map_srgb_encode_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits  = htm_srgb_pkg::FracBitsDef;
  localparam int ChanW     = htm_srgb_pkg::ChanW;
  localparam int CodeW     = htm_srgb_pkg::CodeW;
  localparam int CycleCap  = 200000;
  localparam int DrainWait = 40;
  localparam int RandItems = 1250;

  typedef htm_srgb_pkg::pix_t  pix_t;
  typedef htm_srgb_pkg::code_t code_t;

  // Wide enough for v^5 * 10761^12 (about 277 bits).
  typedef logic [319:0] wide_t;

  // Exact 8-bit sRGB code of one Reinhard-mapped channel.
  function automatic logic [CodeW-1:0] srgb_code_of(logic signed [ChanW-1:0] x);
    logic [63:0] v;
    logic [63:0] den;
    wide_t       lhs;
    wide_t       rhs;
    int          lo;
    int          hi;
    int          mid;
    if (x <= 0) return '0;
    v   = 64'(x);
    den = (64'd1 << FracBits) + v;
    // linear toe of the curve
    if (v * 64'd10000000 <= 64'd31308 * den) return CodeW'((64'd32946 * v) / (64'd10 * den));
    lhs = 1;
    for (int i = 0; i < 5; i++) lhs = lhs * wide_t'(v);
    for (int i = 0; i < 12; i++) lhs = lhs * wide_t'(10761);
    lo = 0;
    hi = 254;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      rhs = 1;
      for (int i = 0; i < 12; i++) rhs = rhs * wide_t'(40 * mid + 561);
      for (int i = 0; i < 5; i++) rhs = rhs * wide_t'(den);
      if (lhs >= rhs) lo = mid;
      else hi = mid - 1;
    end
    return CodeW'(lo);
  endfunction

  class code_scoreboard;
    code_t pending_codes[$];
    int    mismatches;

    function void note_pixel(pix_t p);
      code_t c;
      c.red_code   = srgb_code_of(p.red_linear);
      c.green_code = srgb_code_of(p.green_linear);
      c.blue_code  = srgb_code_of(p.blue_linear);
      pending_codes.push_back(c);
    endfunction

    function void check_code(code_t got);
      code_t exp_c;
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected code beat %h", got);
        return;
      end
      exp_c = pending_codes.pop_front();
      if (got.red_code !== exp_c.red_code || got.green_code !== exp_c.green_code ||
          got.blue_code !== exp_c.blue_code) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: code mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                   exp_c.red_code, exp_c.green_code, exp_c.blue_code,
                   got.red_code, got.green_code, got.blue_code);
      end
    endfunction
  endclass

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start_i = 1'b0;
  pix_t  pix_i = '0;
  logic  busy_o;
  logic  done_o;
  code_t code_o;

  code_scoreboard sb = new();
  int             cycles;
  bit             no_idle;

  always #5 clk_i = ~clk_i;

  hdr_tone_map_srgb_encode_top #(.FracBits(FracBits)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .pix_i  (pix_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .code_o (code_o)
  );

  // Result beats are one-cycle strobes; check each at the edge ending it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_code(code_o);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleCap) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one pixel with optional idle gaps, hold until accepted.
  task automatic send_pixel(pix_t p);
    while (!no_idle && $urandom_range(99) < 23) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      pix_i   <= pix_t'(72'({$urandom, $urandom, $urandom}));
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    pix_i   <= p;
    do @(posedge clk_i); while (busy_o);
    sb.note_pixel(p);
  endtask

  // Random channel, biased toward the interesting ranges.
  function automatic logic signed [ChanW-1:0] rand_chan();
    case ($urandom_range(5))
      0: return ChanW'($urandom_range(400));               // linear toe
      1: return ChanW'($urandom_range(1 << (FracBits + 1))); // around 1.0
      2: return ChanW'($urandom_range(1 << FracBits, 0) + (1 << (FracBits - 2)));
      3: return -ChanW'($urandom_range(1 << 22, 1));        // negative, clamps
      default: return ChanW'($urandom);                    // full range
    endcase
  endfunction

  task automatic send_chans(int r, int g, int b);
    pix_t p;
    p.red_linear   = ChanW'(r);
    p.green_linear = ChanW'(g);
    p.blue_linear  = ChanW'(b);
    send_pixel(p);
  endtask

  initial begin
    pix_t p;
    int   one;
    one = 1 << FracBits;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero, sign extremes, toe/power boundary, unity, saturation side.
    send_chans(0, 0, 0);
    send_chans(-1, -8388608, 8388607);
    send_chans(8388607, 8388607, 8388607);
    send_chans(1, 2, 3);
    send_chans(204, 205, 206);
    send_chans(207, 210, 300);
    send_chans(one, one - 1, one + 1);
    send_chans(one / 2, one * 4, one / 100);
    send_chans(-one, one, 0);
    send_chans(8388606, -2, 100);
    send_chans(5000000, 65, 66);
    send_chans(24'h555555, 24'h2AAAAA, 24'h7FFF00);

    for (int i = 0; i < RandItems; i++) begin
      no_idle = (i >= 400 && i < 650);
      p.red_linear   = rand_chan();
      p.green_linear = rand_chan();
      p.blue_linear  = rand_chan();
      send_pixel(p);
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    while (sb.pending_codes.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_codes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
